@@ rtl/iaws_pkg.sv @@
package iaws_pkg;

  // Default array shape.
  localparam int unsigned DefDepth     = 64;
  localparam int unsigned DefWordWidth = 64;

  // Fixed port widths of one item and one result.
  localparam int unsigned OpWidth       = 3;
  localparam int unsigned PositionWidth = 6;
  localparam int unsigned InWordWidth   = 64;
  localparam int unsigned StatusWidth   = 2;
  localparam int unsigned CountWidth    = 7;

  // Fan-in of one node of the read-back OR tree.
  localparam int unsigned TreeRadix = 8;

  typedef enum logic [OpWidth-1:0] {
    OP_APPEND    = 3'd0,
    OP_INSERT    = 3'd1,
    OP_READ      = 3'd2,
    OP_DELETE    = 3'd3,
    OP_OVERWRITE = 3'd4
  } op_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_e;

  // Command broadcast to every cell of the row.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_DELETE,
    CMD_WRITE,
    CMD_READ
  } cmd_e;

  // Number of nodes on one level of the OR tree; level zero is the leaves.
  function automatic int tree_size(input int leaves, input int lvl);
    int n;
    n = leaves;
    for (int i = 0; i < lvl; i++) begin
      n = (n + TreeRadix - 1) / TreeRadix;
    end
    return n;
  endfunction

  // Number of registered levels until a single root remains.
  function automatic int tree_levels(input int leaves);
    int n;
    int l;
    n = leaves;
    l = 0;
    for (int i = 0; i < 16; i++) begin
      if (n > 1) begin
        n = (n + TreeRadix - 1) / TreeRadix;
        l++;
      end
    end
    if (l == 0) begin
      l = 1;
    end
    return l;
  endfunction

  // Offset of a level's first node in the flat node array (levels from one).
  function automatic int tree_base(input int leaves, input int lvl);
    int b;
    b = 0;
    for (int j = 1; j < lvl; j++) begin
      b += tree_size(leaves, j);
    end
    return b;
  endfunction

endpackage

@@ rtl/iaws_cell.sv @@
module iaws_cell #(
  parameter int unsigned WIDTH = iaws_pkg::DefWordWidth,
  parameter int unsigned POS_W = iaws_pkg::PositionWidth,
  parameter int unsigned INDEX = 0
) (
  input  logic                 clk_i,
  input  iaws_pkg::cmd_e       cmd_i,
  input  logic [POS_W-1:0]     pos_i,
  input  logic [WIDTH-1:0]     word_i,
  input  logic [WIDTH-1:0]     left_i,
  input  logic [WIDTH-1:0]     right_i,
  output logic [WIDTH-1:0]     word_o,
  output logic [WIDTH-1:0]     read_o
);
  import iaws_pkg::*;

  localparam logic [POS_W-1:0] Idx = POS_W'(INDEX);

  logic [WIDTH-1:0] word_q, word_d;

  // Each cell decides on its own whether to keep, load or take a neighbor.
  always_comb begin
    word_d = word_q;
    case (cmd_i)
      CMD_INSERT: begin
        if (Idx > pos_i) begin
          word_d = left_i;
        end else if (Idx == pos_i) begin
          word_d = word_i;
        end
      end
      CMD_DELETE: begin
        if (Idx >= pos_i) begin
          word_d = right_i;
        end
      end
      CMD_WRITE: begin
        if (Idx == pos_i) begin
          word_d = word_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign read_o = (cmd_i == CMD_READ && Idx == pos_i) ? word_q : '0;

endmodule

@@ rtl/iaws_rtree.sv @@
module iaws_rtree #(
  parameter int unsigned WIDTH  = iaws_pkg::DefWordWidth,
  parameter int unsigned LEAVES = iaws_pkg::DefDepth
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] leaf_i [LEAVES],
  output logic [WIDTH-1:0] root_o
);
  import iaws_pkg::*;

  localparam int Levels = tree_levels(LEAVES);
  localparam int Nodes  = tree_base(LEAVES, Levels + 1);

  logic [WIDTH-1:0] node_q [Nodes];

  // Every level is registered; at most one cell's word is nonzero, so OR selects it.
  for (genvar l = 1; l <= Levels; l++) begin : g_lvl
    localparam int Size      = tree_size(LEAVES, l);
    localparam int Base      = tree_base(LEAVES, l);
    localparam int Below     = tree_size(LEAVES, l - 1);
    localparam int BelowBase = (l == 1) ? 0 : tree_base(LEAVES, l - 1);

    for (genvar k = 0; k < Size; k++) begin : g_node
      logic [WIDTH-1:0] or_d;

      if (l == 1) begin : g_leaf
        always_comb begin
          or_d = '0;
          for (int c = 0; c < TreeRadix; c++) begin
            if (k * TreeRadix + c < Below) begin
              or_d = or_d | leaf_i[k * TreeRadix + c];
            end
          end
        end
      end else begin : g_inner
        always_comb begin
          or_d = '0;
          for (int c = 0; c < TreeRadix; c++) begin
            if (k * TreeRadix + c < Below) begin
              or_d = or_d | node_q[BelowBase + k * TreeRadix + c];
            end
          end
        end
      end

      always_ff @(posedge clk_i) begin
        node_q[Base + k] <= or_d;
      end
    end
  end

  assign root_o = node_q[Nodes-1];

endmodule

@@ rtl/indexed_array_with_shift_insert.sv @@
// Bounded ordered array of words held in a row of cells, one word per cell.
// Every item carries one operation: append, insert at a position (later
// words move up one place), read, delete at a position (later words move
// down one place), or overwrite. All cells shift together in the cycle the
// item is accepted, so busy stays low: a new item may start in every clock
// cycle. Each item produces exactly one result, flagged by done_o for a
// single cycle, once its status and count have passed through a result
// pipeline with one register per level of the registered 8-way OR tree
// that collects the word of a read. The receiver cannot hold a result off,
// so it must take every result in the cycle it appears. The result carries
// the read word (zero unless the read was legal), a status (ok, full, or
// index out of range) and the entry count after the item. A full array is
// reported before a bad position on insert. Words are stored at WORD_WIDTH
// bits; upper input bits are dropped and read words are zero-extended. Word
// storage has no reset, and only positions below the count are ever read
// back.
module indexed_array_with_shift_insert #(
  parameter int unsigned DEPTH      = iaws_pkg::DefDepth,
  parameter int unsigned WORD_WIDTH = iaws_pkg::DefWordWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  input  logic [iaws_pkg::OpWidth-1:0]        operation_i,
  input  logic [iaws_pkg::PositionWidth-1:0]  position_i,
  input  logic [iaws_pkg::InWordWidth-1:0]    word_in_i,
  output logic                                busy,
  output logic                                done_o,
  output logic [iaws_pkg::InWordWidth-1:0]    word_out_o,
  output logic [iaws_pkg::StatusWidth-1:0]    status_o,
  output logic [iaws_pkg::CountWidth-1:0]     count_o
);
  import iaws_pkg::*;

  // The count must hold DEPTH itself; positions are compared at a width that
  // fits both the port and the count.
  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam int unsigned PosW   = (CntW > PositionWidth) ? CntW : PositionWidth;
  localparam int          Levels = tree_levels(DEPTH);

  logic                   accept;
  logic                   full;
  logic [PosW-1:0]        pos_ext;
  logic [PosW-1:0]        cnt_ext;
  cmd_e                   cmd;
  logic [PosW-1:0]        cmd_pos;
  status_e                stat_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [WORD_WIDTH-1:0]  word_store;
  logic [WORD_WIDTH-1:0]  cell_word [DEPTH];
  logic [WORD_WIDTH-1:0]  cell_read [DEPTH];
  logic [WORD_WIDTH-1:0]  root_word;

  // Result pipeline, aligned with the levels of the read tree.
  logic                   vld_q  [Levels];
  status_e                stat_q [Levels];
  logic [CntW-1:0]        cntp_q [Levels];

  assign busy       = 1'b0;
  assign accept     = start & ~busy;
  assign full       = (cnt_q == CntW'(DEPTH));
  assign pos_ext    = PosW'(position_i);
  assign cnt_ext    = PosW'(cnt_q);
  assign word_store = word_in_i[WORD_WIDTH-1:0];

  // Decode the item into one command for the whole row and the new count.
  // Append is an insert at the current count.
  always_comb begin
    cmd     = CMD_NONE;
    cmd_pos = pos_ext;
    stat_d  = ST_OK;
    cnt_d   = cnt_q;
    if (accept) begin
      case (op_e'(operation_i))
        OP_APPEND: begin
          if (full) begin
            stat_d = ST_FULL;
          end else begin
            cmd     = CMD_INSERT;
            cmd_pos = cnt_ext;
            cnt_d   = cnt_q + CntW'(1);
          end
        end
        OP_INSERT: begin
          if (full) begin
            stat_d = ST_FULL;
          end else if (pos_ext > cnt_ext) begin
            stat_d = ST_BAD_INDEX;
          end else begin
            cmd   = CMD_INSERT;
            cnt_d = cnt_q + CntW'(1);
          end
        end
        OP_READ: begin
          if (pos_ext >= cnt_ext) begin
            stat_d = ST_BAD_INDEX;
          end else begin
            cmd = CMD_READ;
          end
        end
        OP_DELETE: begin
          if (pos_ext >= cnt_ext) begin
            stat_d = ST_BAD_INDEX;
          end else begin
            cmd   = CMD_DELETE;
            cnt_d = cnt_q - CntW'(1);
          end
        end
        OP_OVERWRITE: begin
          if (pos_ext >= cnt_ext) begin
            stat_d = ST_BAD_INDEX;
          end else begin
            cmd = CMD_WRITE;
          end
        end
        default: begin
          // Unused operation codes change nothing and report ok.
        end
      endcase
    end
  end

  // The row of cells. Each cell sees its left and right neighbor; the first
  // cell never takes from the left and the last one keeps its word on delete.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] left_w;
    logic [WORD_WIDTH-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = word_store;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_word[i];
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end

    iaws_cell #(
      .WIDTH (WORD_WIDTH),
      .POS_W (PosW),
      .INDEX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (cmd_pos),
      .word_i  (word_store),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (cell_word[i]),
      .read_o  (cell_read[i])
    );
  end

  // Read-back: only the addressed cell drives a nonzero word on a legal read.
  iaws_rtree #(
    .WIDTH  (WORD_WIDTH),
    .LEAVES (DEPTH)
  ) u_rtree (
    .clk_i  (clk_i),
    .leaf_i (cell_read),
    .root_o (root_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int s = 0; s < Levels; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      cnt_q    <= cnt_d;
      vld_q[0] <= accept;
      for (int s = 1; s < Levels; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stat_q[0] <= stat_d;
    cntp_q[0] <= cnt_d;
    for (int s = 1; s < Levels; s++) begin
      stat_q[s] <= stat_q[s-1];
      cntp_q[s] <= cntp_q[s-1];
    end
  end

  assign done_o     = vld_q[Levels-1];
  assign word_out_o = InWordWidth'(root_word);
  assign status_o   = stat_q[Levels-1];
  assign count_o    = CountWidth'(cntp_q[Levels-1]);

  // The count never leaves its legal range.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("entry count above capacity");

  // Every accepted item yields its result after the tree latency.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Levels done_o)
    else $error("result missing after accepted item");

  // No result appears without an item accepted that many cycles earlier.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Levels))
    else $error("result without accepted item");

  // A full status only comes with a full array.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (count_o == CountWidth'(DEPTH)))
    else $error("full status with array not full");

  // A failed item never returns a word.
  a_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (word_out_o == '0))
    else $error("word returned with error status");

endmodule
